### rtl/fcst_pkg.sv
package fcst_pkg;

  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 1;

  localparam logic [CFG_IDX_W-1:0] REG_RUN_ENABLE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FUNC_EVENTS_ENABLE = 1'd1;

  localparam logic [1:0] KIND_ENTER = 2'd0;
  localparam logic [1:0] KIND_EXIT = 2'd1;
  localparam logic [1:0] KIND_READ = 2'd2;
  localparam logic [1:0] KIND_CLEAR = 2'd3;

  localparam logic [1:0] STATUS_DONE = 2'd0;
  localparam logic [1:0] STATUS_DISABLED = 2'd1;
  localparam logic [1:0] STATUS_FULL = 2'd2;

  localparam logic [63:0] MIN_NONE = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [31:0] CALLS_MAX = 32'hFFFF_FFFF;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] func_addr;
    logic [63:0] elapsed_time;
    logic [5:0]  slot_index;
  } item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        hit;
    logic [31:0] entry_addr;
    logic [31:0] entry_calls;
    logic [63:0] entry_total_time;
    logic [63:0] entry_min_time;
    logic [63:0] entry_max_time;
    logic [6:0]  entry_count;
  } result_t;

  typedef struct packed {
    logic [31:0] addr;
    logic [31:0] calls;
    logic [63:0] total;
    logic [63:0] low_time;
    logic [63:0] high_time;
  } entry_t;

  typedef enum logic [1:0] {
    RESP_PLAIN,
    RESP_DISABLED,
    RESP_FULL,
    RESP_READ
  } resp_t;

  typedef struct packed {
    logic  latch;
    logic  scan_clr;
    logic  scan_step;
    logic  rd_index;
    logic  upd_hit;
    logic  alloc;
    logic  clear_all;
    logic  respond;
    resp_t resp;
  } cmd_t;

  typedef struct packed {
    logic [1:0] kind;
    logic       enabled;
    logic       match;
    logic       last;
    logic       free_found;
  } sts_t;

endpackage

### rtl/fcst_ctrl.sv
module fcst_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  fcst_pkg::sts_t sts,
  output fcst_pkg::cmd_t cmd,
  output logic          busy
);
  import fcst_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISPATCH,
    S_SCAN,
    S_UPDATE,
    S_READ,
    S_FINISH
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      busy <= 1'b0;
    end else begin
      state <= state_next;
      busy <= (state_next != S_IDLE);
    end
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    cmd.resp = RESP_PLAIN;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          cmd.latch = 1'b1;
          state_next = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        unique case (sts.kind) inside
          KIND_ENTER, KIND_EXIT: begin
            if (!sts.enabled) begin
              cmd.respond = 1'b1;
              cmd.resp = RESP_DISABLED;
              state_next = S_IDLE;
            end else begin
              cmd.scan_clr = 1'b1;
              state_next = S_SCAN;
            end
          end
          KIND_READ: begin
            cmd.rd_index = 1'b1;
            state_next = S_READ;
          end
          default: begin
            cmd.clear_all = 1'b1;
            state_next = S_FINISH;
          end
        endcase
      end
      S_SCAN: begin
        if (sts.match) begin
          state_next = S_UPDATE;
        end else if (sts.last) begin
          if (sts.kind == KIND_EXIT) begin
            state_next = S_FINISH;
          end else if (sts.free_found) begin
            cmd.alloc = 1'b1;
            state_next = S_FINISH;
          end else begin
            cmd.respond = 1'b1;
            cmd.resp = RESP_FULL;
            state_next = S_IDLE;
          end
        end else begin
          cmd.scan_step = 1'b1;
        end
      end
      S_UPDATE: begin
        cmd.upd_hit = 1'b1;
        state_next = S_FINISH;
      end
      S_READ: begin
        cmd.respond = 1'b1;
        cmd.resp = RESP_READ;
        state_next = S_IDLE;
      end
      S_FINISH: begin
        cmd.respond = 1'b1;
        cmd.resp = RESP_PLAIN;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

### rtl/fcst_datapath.sv
module fcst_datapath #(
  parameter int SLOTS = 64
) (
  input  logic                               clk,
  input  logic                               rst,
  input  fcst_pkg::item_t                    item,
  input  logic                               cfg_we,
  input  logic [fcst_pkg::CFG_IDX_W-1:0]     cfg_idx,
  input  logic [fcst_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  input  fcst_pkg::cmd_t                     cmd,
  output fcst_pkg::sts_t                     sts,
  output fcst_pkg::result_t                  result,
  output logic                               done
);
  import fcst_pkg::*;

  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int PW = $clog2(SLOTS + 1);
  localparam int XW = ((IW > 6) ? IW : 6) + 1;

  item_t            cur;
  logic             run_enable;
  logic             function_events_enable;
  logic [SLOTS-1:0] valid;
  logic [PW-1:0]    count;
  logic [PW-1:0]    ptr;
  logic [IW-1:0]    ptr_idx;
  logic [IW-1:0]    cmp_idx;
  logic [IW-1:0]    free_idx;
  logic [IW-1:0]    rd_addr;
  logic [IW-1:0]    wr_addr;
  logic [XW-1:0]    idx_x;
  logic             cmp_vld;
  logic             free_found;
  logic             hit_flag;
  logic             ptr_end;
  logic             rd_en;
  logic             wr_en;
  logic             in_range;
  logic             read_hit;
  entry_t           mem [SLOTS];
  entry_t           rdata;
  entry_t           wr_data;
  entry_t           upd_entry;
  result_t          result_next;

  assign ptr_idx = ptr[IW-1:0];
  assign ptr_end = (ptr == PW'(SLOTS));
  assign idx_x = XW'(cur.slot_index);
  assign in_range = (idx_x < XW'(SLOTS));
  assign read_hit = in_range & valid[idx_x[IW-1:0]];

  assign rd_en = cmd.rd_index | (cmd.scan_step & ~ptr_end);
  assign rd_addr = cmd.rd_index ? idx_x[IW-1:0] : ptr_idx;

  assign sts.kind = cur.kind;
  assign sts.enabled = run_enable & function_events_enable;
  assign sts.match = cmp_vld & valid[cmp_idx] & (rdata.addr == cur.func_addr);
  assign sts.last = cmp_vld & (cmp_idx == IW'(SLOTS - 1));
  assign sts.free_found = free_found;

  // read-modify-write of the matching slot
  always_comb begin
    upd_entry = rdata;
    if (cur.kind == KIND_ENTER) begin
      if (rdata.calls != CALLS_MAX) begin
        upd_entry.calls = rdata.calls + 32'd1;
      end
    end else begin
      upd_entry.total = rdata.total + cur.elapsed_time;
      if (cur.elapsed_time < rdata.low_time) begin
        upd_entry.low_time = cur.elapsed_time;
      end
      if (cur.elapsed_time > rdata.high_time) begin
        upd_entry.high_time = cur.elapsed_time;
      end
    end
  end

  always_comb begin
    wr_en = cmd.upd_hit | cmd.alloc;
    wr_addr = cmd.alloc ? free_idx : cmp_idx;
    if (cmd.alloc) begin
      wr_data.addr = cur.func_addr;
      wr_data.calls = 32'd1;
      wr_data.total = '0;
      wr_data.low_time = MIN_NONE;
      wr_data.high_time = '0;
    end else begin
      wr_data = upd_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata <= mem[rd_addr];
    end
  end

  always_comb begin
    result_next = '0;
    result_next.entry_count = 7'(count);
    unique case (cmd.resp)
      RESP_DISABLED: result_next.status = STATUS_DISABLED;
      RESP_FULL:     result_next.status = STATUS_FULL;
      RESP_READ: begin
        result_next.status = STATUS_DONE;
        if (read_hit) begin
          result_next.hit = 1'b1;
          result_next.entry_addr = rdata.addr;
          result_next.entry_calls = rdata.calls;
          result_next.entry_total_time = rdata.total;
          result_next.entry_min_time = rdata.low_time;
          result_next.entry_max_time = rdata.high_time;
        end
      end
      default: begin
        result_next.status = STATUS_DONE;
        result_next.hit = hit_flag;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      cur <= item;
    end
    if (cmd.scan_step & ~ptr_end) begin
      cmp_idx <= ptr_idx;
    end
    if (cmd.respond) begin
      result <= result_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run_enable <= 1'b0;
      function_events_enable <= 1'b0;
      valid <= '0;
      count <= '0;
      ptr <= '0;
      cmp_vld <= 1'b0;
      free_found <= 1'b0;
      free_idx <= '0;
      hit_flag <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= cmd.respond;
      cmp_vld <= cmd.scan_step & ~ptr_end;
      if (cfg_we) begin
        unique case (cfg_idx)
          REG_RUN_ENABLE:         run_enable <= cfg_wdata[0];
          REG_FUNC_EVENTS_ENABLE: function_events_enable <= cfg_wdata[0];
          default: ;
        endcase
      end
      if (cmd.scan_clr) begin
        ptr <= '0;
        free_found <= 1'b0;
        hit_flag <= 1'b0;
      end else if (cmd.scan_step & ~ptr_end) begin
        ptr <= ptr + PW'(1);
        // lowest free slot, picked up as the scan passes it
        if (!free_found && !valid[ptr_idx]) begin
          free_found <= 1'b1;
          free_idx <= ptr_idx;
        end
      end
      if (cmd.latch) begin
        hit_flag <= 1'b0;
      end
      if (cmd.upd_hit) begin
        hit_flag <= 1'b1;
      end
      if (cmd.alloc) begin
        valid[free_idx] <= 1'b1;
        count <= count + PW'(1);
      end
      if (cmd.clear_all) begin
        valid <= '0;
        count <= '0;
      end
    end
  end

endmodule

### rtl/function_call_stats_table_top.sv
// Per-function statistics table keyed by a 32-bit function address. A word
// is taken when start is high and busy is low; busy then stays high until the
// one result word appears on result for a single cycle with done high, and
// the receiver must take it in that cycle. Enter and exit scan the statistics
// memory one slot per clock through its single read port; a scan stops at a
// matching slot and a miss scans every slot, while a disabled enter or exit
// is answered without a scan. The next word can be started in the cycle done
// is high. Configuration writes are taken at each edge with cfg_we high; the
// user must write them only while no word is in progress, as the block does
// not enforce it.
module function_call_stats_table_top #(
  parameter int TABLE_SLOTS = 64
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  output logic                               busy,
  input  fcst_pkg::item_t                    item,
  output logic                               done,
  output fcst_pkg::result_t                  result,
  input  logic                               cfg_we,
  input  logic [fcst_pkg::CFG_IDX_W-1:0]     cfg_idx,
  input  logic [fcst_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
  import fcst_pkg::*;

  cmd_t cmd;
  sts_t sts;

  fcst_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy)
  );

  fcst_datapath #(
    .SLOTS (TABLE_SLOTS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .item      (item),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .sts       (sts),
    .result    (result),
    .done      (done)
  );

endmodule

### rtl/fcst_checker.sv
module fcst_checker (
  input logic              clk,
  input logic              rst,
  input logic              start,
  input logic              busy,
  input logic              done,
  input fcst_pkg::result_t result
);
  import fcst_pkg::*;

  a_start_sets_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("busy not raised after start");

  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result word without work in progress");

  a_done_frees: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("busy still high with result word");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    done |-> (result.status == STATUS_DONE || result.status == STATUS_DISABLED ||
              result.status == STATUS_FULL))
    else $error("bad status code");

  a_no_hit_on_fail: assert property (@(posedge clk) disable iff (rst)
    (done && result.status != STATUS_DONE) |-> !result.hit)
    else $error("hit set on disabled or full");

endmodule

bind function_call_stats_table_top fcst_checker u_fcst_checker (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .done   (done),
  .result (result)
);

### tb/tb_function_call_stats_table_top.sv
module tb_function_call_stats_table_top;
  import fcst_pkg::*;

  localparam int SLOTS = 64;
  localparam int POOL_SIZE = 80;

  logic clk;
  logic rst;
  logic start;
  logic busy;
  item_t item;
  logic done;
  result_t result;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  function_call_stats_table_top #(
    .TABLE_SLOTS(SLOTS)
  ) u_top (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .item(item),
    .done(done),
    .result(result),
    .cfg_we(cfg_we),
    .cfg_idx(cfg_idx),
    .cfg_wdata(cfg_wdata)
  );

  // predictor copy of the table and the enables
  logic        run_en;
  logic        fev_en;
  logic        tbl_valid [SLOTS];
  logic [31:0] tbl_addr [SLOTS];
  logic [31:0] tbl_calls [SLOTS];
  logic [63:0] tbl_total [SLOTS];
  logic [63:0] tbl_min [SLOTS];
  logic [63:0] tbl_max [SLOTS];
  logic [6:0]  tbl_count;

  result_t stats_expected[$];
  logic [31:0] addr_pool [POOL_SIZE];
  int failures;
  int gap_max;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #4000000;
    $display("FAILED: results differ");
    $finish;
  end

  function automatic int find_entry(input logic [31:0] addr);
    for (int i = 0; i < SLOTS; i++) begin
      if (tbl_valid[i] && tbl_addr[i] == addr) return i;
    end
    return -1;
  endfunction

  function automatic result_t predict_stats(input item_t w);
    result_t r;
    int s;
    r = '0;
    r.status = STATUS_DONE;
    case (w.kind)
      KIND_ENTER: begin
        if (!(run_en && fev_en)) begin
          r.status = STATUS_DISABLED;
        end else begin
          s = find_entry(w.func_addr);
          if (s >= 0) begin
            r.hit = 1'b1;
            if (tbl_calls[s] != CALLS_MAX) tbl_calls[s] = tbl_calls[s] + 32'd1;
          end else begin
            for (int i = 0; i < SLOTS; i++) begin
              if (s < 0 && !tbl_valid[i]) s = i;
            end
            if (s < 0) begin
              r.status = STATUS_FULL;
            end else begin
              tbl_valid[s] = 1'b1;
              tbl_addr[s] = w.func_addr;
              tbl_calls[s] = 32'd1;
              tbl_total[s] = '0;
              tbl_min[s] = MIN_NONE;
              tbl_max[s] = '0;
              tbl_count = tbl_count + 7'd1;
            end
          end
        end
      end
      KIND_EXIT: begin
        if (!(run_en && fev_en)) begin
          r.status = STATUS_DISABLED;
        end else begin
          s = find_entry(w.func_addr);
          if (s >= 0) begin
            r.hit = 1'b1;
            tbl_total[s] = tbl_total[s] + w.elapsed_time;
            if (w.elapsed_time < tbl_min[s]) tbl_min[s] = w.elapsed_time;
            if (w.elapsed_time > tbl_max[s]) tbl_max[s] = w.elapsed_time;
          end
        end
      end
      KIND_READ: begin
        if (tbl_valid[w.slot_index]) begin
          r.hit = 1'b1;
          r.entry_addr = tbl_addr[w.slot_index];
          r.entry_calls = tbl_calls[w.slot_index];
          r.entry_total_time = tbl_total[w.slot_index];
          r.entry_min_time = tbl_min[w.slot_index];
          r.entry_max_time = tbl_max[w.slot_index];
        end
      end
      default: begin
        for (int i = 0; i < SLOTS; i++) tbl_valid[i] = 1'b0;
        tbl_count = '0;
      end
    endcase
    r.entry_count = tbl_count;
    return r;
  endfunction

  task automatic check_field(input string name, input logic [63:0] want, input logic [63:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      failures++;
    end
  endtask

  always @(posedge clk) begin : check_result
    result_t want;
    if (!rst && done === 1'b1) begin
      if (stats_expected.size() == 0) begin
        $error("result word with nothing expected: %0h", result);
        failures++;
      end else begin
        want = stats_expected.pop_front();
        check_field("status", 64'(want.status), 64'(result.status));
        check_field("hit", 64'(want.hit), 64'(result.hit));
        check_field("entry_addr", 64'(want.entry_addr), 64'(result.entry_addr));
        check_field("entry_calls", 64'(want.entry_calls), 64'(result.entry_calls));
        check_field("entry_total_time", want.entry_total_time, result.entry_total_time);
        check_field("entry_min_time", want.entry_min_time, result.entry_min_time);
        check_field("entry_max_time", want.entry_max_time, result.entry_max_time);
        check_field("entry_count", 64'(want.entry_count), 64'(result.entry_count));
      end
    end
  end

  task automatic send_word(input item_t w);
    int gap;
    start <= 1'b1;
    item <= w;
    @(posedge clk);
    while (busy) @(posedge clk);
    stats_expected.push_back(predict_stats(w));
    gap = $urandom_range(0, gap_max);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_fields(input logic [1:0] kind, input logic [31:0] addr,
                             input logic [63:0] t, input logic [5:0] idx);
    item_t w;
    w.kind = kind;
    w.func_addr = addr;
    w.elapsed_time = t;
    w.slot_index = idx;
    send_word(w);
  endtask

  task automatic drain_results();
    start <= 1'b0;
    while (stats_expected.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // only called with the block idle
  task automatic set_enables(input logic run, input logic fev);
    cfg_we <= 1'b1;
    cfg_idx <= REG_RUN_ENABLE;
    cfg_wdata <= run;
    @(posedge clk);
    cfg_idx <= REG_FUNC_EVENTS_ENABLE;
    cfg_wdata <= fev;
    @(posedge clk);
    cfg_we <= 1'b0;
    run_en = run;
    fev_en = fev;
  endtask

  function automatic logic [63:0] random_time();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return MIN_NONE;
      2: return 64'($urandom_range(0, 1000));
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic item_t random_word();
    item_t w;
    int r;
    r = $urandom_range(0, 199);
    w.func_addr = addr_pool[$urandom_range(0, POOL_SIZE - 1)];
    w.elapsed_time = random_time();
    w.slot_index = 6'($urandom);
    if (r < 90) begin
      w.kind = KIND_ENTER;
    end else if (r < 170) begin
      w.kind = KIND_EXIT;
    end else if (r < 188) begin
      w.kind = KIND_READ;
    end else if (r < 198) begin
      w.kind = r[0] ? KIND_EXIT : KIND_ENTER;
      w.func_addr = $urandom;
    end else begin
      w.kind = KIND_CLEAR;
    end
    return w;
  endfunction

  task automatic test_disabled_events();
    send_fields(KIND_ENTER, 32'h0000_1000, '0, '0);
    send_fields(KIND_EXIT, 32'h0000_1000, 64'd7, '0);
    send_fields(KIND_READ, '0, '0, 6'd0);
    send_fields(KIND_CLEAR, '0, '0, '0);
    drain_results();
    set_enables(1'b1, 1'b0);
    send_fields(KIND_ENTER, 32'hFFFF_FFFF, '0, '0);
    send_fields(KIND_EXIT, 32'hFFFF_FFFF, MIN_NONE, '0);
    drain_results();
    set_enables(1'b0, 1'b1);
    send_fields(KIND_ENTER, 32'h0, '0, '0);
    send_fields(KIND_EXIT, 32'h0, '0, '0);
    drain_results();
  endtask

  task automatic test_enter_exit_read();
    set_enables(1'b1, 1'b1);
    send_fields(KIND_ENTER, 32'h0, '0, '0);
    send_fields(KIND_ENTER, 32'hFFFF_FFFF, '0, '0);
    send_fields(KIND_ENTER, 32'h0, '0, '0);
    send_fields(KIND_EXIT, 32'h0, '0, 6'd63);
    send_fields(KIND_EXIT, 32'h0, MIN_NONE, '0);
    send_fields(KIND_EXIT, 32'h0, 64'd5, '0);
    send_fields(KIND_EXIT, 32'hFFFF_FFFF, 64'h8000_0000_0000_0000, '0);
    send_fields(KIND_EXIT, 32'h1234_5678, 64'd99, '0);
    send_fields(KIND_ENTER, 32'hFFFF_FFFF, '0, '0);
    send_fields(KIND_READ, 32'hFFFF_FFFF, MIN_NONE, 6'd0);
    send_fields(KIND_READ, '0, '0, 6'd1);
    send_fields(KIND_READ, '0, '0, 6'd2);
    send_fields(KIND_READ, '0, '0, 6'd63);
    send_fields(KIND_CLEAR, 32'hFFFF_FFFF, MIN_NONE, 6'd63);
    send_fields(KIND_READ, '0, '0, 6'd0);
    send_fields(KIND_EXIT, 32'h0, 64'd3, '0);
    send_fields(KIND_ENTER, 32'hA5A5_A5A5, '0, '0);
    send_fields(KIND_READ, '0, '0, 6'd0);
    drain_results();
  endtask

  task automatic test_table_full();
    logic [31:0] base;
    base = $urandom;
    send_fields(KIND_CLEAR, '0, '0, '0);
    for (int i = 0; i < SLOTS; i++) begin
      send_fields(KIND_ENTER, {base[31:6], 6'(i)}, '0, '0);
    end
    send_fields(KIND_ENTER, {~base[31:6], 6'd0}, '0, '0);
    send_fields(KIND_EXIT, {~base[31:6], 6'd0}, 64'd1, '0);
    send_fields(KIND_ENTER, {base[31:6], 6'd63}, '0, '0);
    send_fields(KIND_EXIT, {base[31:6], 6'd63}, random_time(), '0);
    send_fields(KIND_READ, '0, '0, 6'd63);
    send_fields(KIND_CLEAR, '0, '0, '0);
    drain_results();
  endtask

  task automatic run_random_phase(input logic run, input logic fev, input int count,
                                  input int gmax, input int pause_every);
    set_enables(run, fev);
    gap_max = gmax;
    for (int n = 1; n <= count; n++) begin
      send_word(random_word());
      if (pause_every != 0 && n % pause_every == 0) drain_results();
    end
    drain_results();
  endtask

  task automatic test_random_traffic();
    addr_pool[0] = 32'h0;
    addr_pool[1] = 32'hFFFF_FFFF;
    for (int i = 2; i < POOL_SIZE; i++) addr_pool[i] = $urandom;
    run_random_phase(1'b1, 1'b1, 300, 19, 0);
    run_random_phase(1'b0, 1'b1, 40, 19, 0);
    run_random_phase(1'b1, 1'b0, 40, 19, 0);
    run_random_phase(1'b0, 1'b0, 40, 19, 0);
    run_random_phase(1'b1, 1'b1, 200, 0, 0);
    run_random_phase(1'b1, 1'b1, 280, 19, 50);
  endtask

  initial begin
    failures = 0;
    gap_max = 19;
    run_en = 1'b0;
    fev_en = 1'b0;
    tbl_count = '0;
    for (int i = 0; i < SLOTS; i++) tbl_valid[i] = 1'b0;
    rst <= 1'b1;
    start <= 1'b0;
    item <= '0;
    cfg_we <= 1'b0;
    cfg_idx <= '0;
    cfg_wdata <= '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_disabled_events();
    test_enter_exit_read();
    test_table_full();
    test_random_traffic();
    drain_results();
    repeat (SLOTS + 10) @(posedge clk);
    if (failures == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
